/* hw/rtl/hbp_pkg.sv */
// Package for the Huffman bit packer: item types, queue entry type, kind codes
// and size constants.
// No dependencies; every file in hw/rtl but hbp_ram imports it.
`default_nettype none

package hbp_pkg;

	localparam int SYM_COUNT    = 256;
	localparam int SYM_W        = 8;
	localparam int CODE_W       = 32;
	localparam int LEN_W        = 6;
	localparam int BYTE_W       = 8;
	localparam int KIND_W       = 2;
	localparam int MAX_CODE_LEN = 32;
	localparam int CODE_CAP     = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	// Up to seven pending bits sit above a full-length code.
	localparam int ACC_W        = CODE_W + BYTE_W - 1;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SYM_W-1:0]  symbol;
		logic [CODE_W-1:0] entry_code;
		logic [LEN_W-1:0]  entry_length;
	} hbp_cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last;
	} hbp_pkt_t;

	typedef struct packed {
		logic              flush;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} hbp_qent_t;

	typedef struct packed {
		logic      push;
		hbp_qent_t ent;
	} hbp_qwr_t;

	typedef struct packed {
		logic      nempty;
		hbp_qent_t ent;
	} hbp_qrd_t;

endpackage

`default_nettype wire

/* hw/rtl/hbp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module hbp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/hbp_front.sv */
// Front end of the bit packer: takes items, keeps the code table and turns
// encode and flush items into queue entries. Uses hbp_pkg and hbp_ram.
`default_nettype none

module hbp_front import hbp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cmd_valid,
	output logic          cmd_stall,
	input  wire hbp_cmd_t cmd,
	input  wire logic     q_full,
	output hbp_qwr_t      q_wr
);

	logic                  accept;
	logic                  is_load;
	logic                  is_encode;
	logic [LEN_W-1:0]      len_clamped;
	logic [CODE_W-1:0]     code_rdata;
	logic [LEN_W-1:0]      len_rdata;
	logic [LEN_W-1:0]      len_eff;
	logic [CODE_W:0]       code_mask;
	logic [SYM_COUNT-1:0]  len_vld_q;
	logic                  s1_valid_q;
	logic                  s1_flush_q;
	logic                  s1_lv_q;

	assign accept    = cmd_valid && !cmd_stall;
	assign is_load   = (cmd.kind == KIND_LOAD);
	assign is_encode = (cmd.kind == KIND_ENCODE);
	assign cmd_stall = s1_valid_q && q_full;

	assign len_clamped = (cmd.entry_length > LEN_W'(CODE_CAP)) ? LEN_W'(CODE_CAP)
	                                                           : cmd.entry_length;

	hbp_ram #(.WIDTH(CODE_W), .DEPTH(SYM_COUNT)) u_code_ram (
		.clk   (clk),
		.we    (accept && is_load),
		.waddr (cmd.symbol),
		.wdata (cmd.entry_code),
		.re    (accept && is_encode),
		.raddr (cmd.symbol),
		.rdata (code_rdata)
	);

	hbp_ram #(.WIDTH(LEN_W), .DEPTH(SYM_COUNT)) u_len_ram (
		.clk   (clk),
		.we    (accept && is_load),
		.waddr (cmd.symbol),
		.wdata (len_clamped),
		.re    (accept && is_encode),
		.raddr (cmd.symbol),
		.rdata (len_rdata)
	);

	// A symbol never loaded since reset has length zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_vld_q <= '0;
		end else if (accept && is_load) begin
			len_vld_q[cmd.symbol] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s1_flush_q <= 1'b0;
			s1_lv_q    <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= is_encode || (cmd.kind == KIND_FLUSH);
			s1_flush_q <= (cmd.kind == KIND_FLUSH);
			s1_lv_q    <= len_vld_q[cmd.symbol];
		end else if (!q_full) begin
			s1_valid_q <= 1'b0;
		end
	end

	assign len_eff   = s1_lv_q ? len_rdata : '0;
	assign code_mask = ((CODE_W+1)'(1) << len_eff) - (CODE_W+1)'(1);

	// Zero-length encodes are dropped here and never reach the packer.
	always_comb begin
		q_wr.push      = s1_valid_q && !q_full && (s1_flush_q || (len_eff != '0));
		q_wr.ent.flush = s1_flush_q;
		q_wr.ent.len   = len_eff;
		q_wr.ent.code  = code_rdata & code_mask[CODE_W-1:0];
	end

endmodule

`default_nettype wire

/* hw/rtl/hbp_queue.sv */
// Short queue of packer work between the front and back ends.
// Uses hbp_pkg for the entry types.
`default_nettype none

module hbp_queue import hbp_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire hbp_qwr_t q_wr,
	output logic          q_full,
	input  wire logic     q_pop,
	output hbp_qrd_t      q_rd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	hbp_qent_t        ent_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign q_full    = (count_q == CNT_W'(DEPTH));
	assign q_rd.nempty = (count_q != '0);
	assign q_rd.ent  = ent_q[rd_ptr_q];
	assign do_push   = q_wr.push && !q_full;
	assign do_pop    = q_pop && q_rd.nempty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= q_wr.ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/hbp_back.sv */
// Back end of the bit packer: merges codes into the pending bits and sends
// bytes out through an output register, one a cycle unless stalled. Uses hbp_pkg.
`default_nettype none

module hbp_back import hbp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire hbp_qrd_t q_rd,
	output logic          q_pop,
	output logic          pkt_valid,
	input  wire logic     pkt_stall,
	output hbp_pkt_t      pkt
);

	logic [ACC_W-1:0]  acc_q;
	logic [LEN_W-1:0]  tot_q;
	logic              pkt_valid_q;
	hbp_pkt_t          pkt_q;

	logic              out_free;
	logic              have_byte;
	logic [BYTE_W-1:0] pend8;
	logic [ACC_W-1:0]  acc_shr;
	logic [BYTE_W-1:0] flush_byte;
	logic              load_out;
	hbp_pkt_t          pkt_next;
	logic [ACC_W-1:0]  acc_next;
	logic [LEN_W-1:0]  tot_next;

	assign out_free  = !pkt_valid_q || !pkt_stall;
	assign have_byte = (tot_q >= LEN_W'(BYTE_W));
	// Only meaningful while fewer than eight bits are held.
	assign pend8      = acc_q[BYTE_W-1:0] & ~(BYTE_W'({BYTE_W{1'b1}}) << tot_q);
	assign acc_shr    = acc_q >> (tot_q - LEN_W'(BYTE_W));
	assign flush_byte = pend8 << (4'(BYTE_W) - {1'b0, tot_q[2:0]});

	always_comb begin
		q_pop    = 1'b0;
		load_out = 1'b0;
		pkt_next = pkt_q;
		acc_next = acc_q;
		tot_next = tot_q;
		if (have_byte) begin
			if (out_free) begin
				load_out          = 1'b1;
				pkt_next.out_byte = acc_shr[BYTE_W-1:0];
				pkt_next.last     = (tot_q < LEN_W'(2 * BYTE_W));
				tot_next          = tot_q - LEN_W'(BYTE_W);
			end
		end else if (q_rd.nempty) begin
			if (q_rd.ent.flush) begin
				// An empty flush is simply dropped.
				if (tot_q == '0) begin
					q_pop = 1'b1;
				end else if (out_free) begin
					q_pop             = 1'b1;
					load_out          = 1'b1;
					pkt_next.out_byte = flush_byte;
					pkt_next.last     = 1'b1;
					tot_next          = '0;
				end
			end else begin
				q_pop    = 1'b1;
				acc_next = (ACC_W'(pend8[BYTE_W-2:0]) << q_rd.ent.len)
				           | ACC_W'(q_rd.ent.code);
				tot_next = tot_q + q_rd.ent.len;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			tot_q       <= '0;
			pkt_valid_q <= 1'b0;
		end else begin
			acc_q <= acc_next;
			tot_q <= tot_next;
			if (load_out) begin
				pkt_valid_q <= 1'b1;
			end else if (!pkt_stall) begin
				pkt_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pkt_q <= pkt_next;
		end
	end

	assign pkt_valid = pkt_valid_q;
	assign pkt       = pkt_q;

endmodule

`default_nettype wire

/* hw/rtl/huffman_bit_packer_core.sv */
// Huffman bit packer: a load item writes one code table entry (lengths above
// 32 saturate), an encode item appends its symbol's code to the pending bits
// most significant bit first, and a flush item sends the partial byte padded
// with low zeros, or nothing if no bits are pending. Every full byte goes out
// as one item, with last set on the final byte an input item causes. The
// front end takes one item a cycle while it is not stalled; each item passes
// the registered table lookup and the queue before the back end sees it, and
// its bytes leave through the output register. The back end sends one byte a
// cycle while the output is not stalled: an encode item is merged into the
// pending bits, and each byte it completes (up to four) goes out before the
// next item is taken; a flush sends at most one byte. No clearing pass is
// needed after reset: table lengths read as zero until loaded.
`default_nettype none

module huffman_bit_packer_core import hbp_pkg::*; #(
	parameter int Q_DEPTH = QUEUE_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cmd_valid,
	output logic          cmd_stall,
	input  wire hbp_cmd_t cmd,
	output logic          pkt_valid,
	input  wire logic     pkt_stall,
	output hbp_pkt_t      pkt
);

	hbp_qwr_t q_wr;
	hbp_qrd_t q_rd;
	logic     q_full;
	logic     q_pop;

	hbp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.q_full    (q_full),
		.q_wr      (q_wr)
	);

	hbp_queue #(.DEPTH(Q_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.q_full (q_full),
		.q_pop  (q_pop),
		.q_rd   (q_rd)
	);

	hbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_rd      (q_rd),
		.q_pop     (q_pop),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.pkt       (pkt)
	);

	// The front end must never offer work the queue cannot take.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_wr.push)
		else $error("queue push while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_rd.nempty)
		else $error("queue pop while empty");

	// Encode entries carry a real, saturated length.
	a_enc_len: assert property (@(posedge clk) disable iff (!arst_n)
		(q_wr.push && !q_wr.ent.flush) |->
			(q_wr.ent.len != '0) && (q_wr.ent.len <= LEN_W'(CODE_CAP)))
		else $error("encode entry with bad length");

	// A stalled input side means the lookup stage is waiting on a full queue.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> q_full)
		else $error("input stalled without a full queue");

endmodule

`default_nettype wire

/* bench/tb_huffman_bit_packer_core.sv */
// Self-checking testbench for huffman_bit_packer_core: table loads, encodes and flushes
// with random idling on both channels, checked byte by byte against a behavioural predictor.
// Depends on hbp_pkg and the huffman_bit_packer_core RTL only.
`timescale 1ns / 100ps

module tb_huffman_bit_packer_core;
	import hbp_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_ITEMS  = 390;
	localparam int SETTLE_CYCLES = 30;

	typedef enum int {STALL_NONE, STALL_HALF, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

	// Predicts the byte stream of the packer and checks the bytes that come out.
	class hbp_scoreboard;
		logic [CODE_W-1:0] codes [SYM_COUNT];
		logic [LEN_W-1:0]  lens [SYM_COUNT];
		logic [BYTE_W-1:0] pend_bits;
		int unsigned       pend_count;
		hbp_pkt_t          byte_q [$];
		int                errors;

		function new();
			foreach (lens[i]) begin
				lens[i]  = '0;
				codes[i] = '0;
			end
			pend_bits  = '0;
			pend_count = 0;
			errors     = 0;
		endfunction

		function void note_cmd(hbp_cmd_t c);
			logic [63:0] wide;
			int unsigned len;
			int unsigned total;
			int unsigned nbytes;
			hbp_pkt_t    b;
			case (c.kind)
				KIND_LOAD: begin
					codes[c.symbol] = c.entry_code;
					lens[c.symbol]  = (c.entry_length > CODE_CAP) ? LEN_W'(CODE_CAP)
						: c.entry_length;
				end
				KIND_ENCODE: begin
					len = lens[c.symbol];
					if (len != 0) begin
						wide = (64'(pend_bits) << len)
							| (64'(codes[c.symbol]) & ((64'd1 << len) - 64'd1));
						total  = pend_count + len;
						nbytes = total / BYTE_W;
						for (int i = 0; i < nbytes; i++) begin
							b.out_byte = 8'(wide >> (total - BYTE_W * (i + 1)));
							b.last     = (i == nbytes - 1);
							byte_q.push_back(b);
						end
						total      = total % BYTE_W;
						pend_bits  = 8'(wide & ((64'd1 << total) - 64'd1));
						pend_count = total;
					end
				end
				KIND_FLUSH: begin
					if (pend_count != 0) begin
						b.out_byte = 8'(pend_bits << (BYTE_W - pend_count));
						b.last     = 1'b1;
						byte_q.push_back(b);
						pend_bits  = '0;
						pend_count = 0;
					end
				end
				default: ;
			endcase
		endfunction

		function void check_pkt(hbp_pkt_t p);
			hbp_pkt_t e;
			if (byte_q.size() == 0) begin
				$error("out_byte: no byte expected, got %02h (last %0b)", p.out_byte, p.last);
				errors++;
				return;
			end
			e = byte_q.pop_front();
			if (p.out_byte !== e.out_byte) begin
				$error("out_byte: expected %02h, got %02h", e.out_byte, p.out_byte);
				errors++;
			end
			if (p.last !== e.last) begin
				$error("last: expected %0b, got %0b", e.last, p.last);
				errors++;
			end
		endfunction

		function int outstanding();
			return byte_q.size();
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n;
	logic     cmd_valid;
	logic     cmd_stall;
	hbp_cmd_t cmd;
	logic     pkt_valid;
	logic     pkt_stall;
	hbp_pkt_t pkt;

	hbp_scoreboard sb;

	bit         sym_loaded [SYM_COUNT];
	logic [7:0] sym_list [$];
	int         burst_left;
	int         flood_left;
	int         hold_ask;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	huffman_bit_packer_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.pkt       (pkt)
	);

	// Unused fields of every item carry random junk, which the block must ignore.
	function automatic hbp_cmd_t op_cmd(logic [KIND_W-1:0] kind, logic [SYM_W-1:0] sym);
		hbp_cmd_t c;
		c.kind         = kind;
		c.symbol       = sym;
		c.entry_code   = $urandom;
		c.entry_length = LEN_W'($urandom);
		return c;
	endfunction

	function automatic hbp_cmd_t load_cmd(logic [SYM_W-1:0] sym, logic [CODE_W-1:0] code,
			logic [LEN_W-1:0] len);
		hbp_cmd_t c;
		c.kind         = KIND_LOAD;
		c.symbol       = sym;
		c.entry_code   = code;
		c.entry_length = len;
		// Only symbols whose code has been written are ever encoded.
		if (!sym_loaded[sym]) begin
			sym_loaded[sym] = 1'b1;
			sym_list.push_back(sym);
		end
		return c;
	endfunction

	function automatic hbp_cmd_t random_cmd();
		int r;
		int lsel;
		logic [LEN_W-1:0] len;
		r = $urandom_range(99);
		if (r < 14 || sym_list.size() == 0) begin
			lsel = $urandom_range(19);
			if (lsel == 0)
				len = '0;
			else if (lsel == 1)
				len = LEN_W'($urandom_range(63, 33));
			else if (lsel < 8)
				len = LEN_W'($urandom_range(32, 1));
			else
				len = LEN_W'($urandom_range(12, 1));
			return load_cmd(SYM_W'($urandom_range(255)), $urandom, len);
		end
		if (r < 26)
			return op_cmd(KIND_FLUSH, SYM_W'($urandom));
		if (r < 29)
			return op_cmd(KIND_UNUSED, SYM_W'($urandom));
		return op_cmd(KIND_ENCODE, sym_list[$urandom_range(sym_list.size() - 1)]);
	endfunction

	// Offers one item until it is taken, then either carries on or leaves a gap.
	task automatic offer_cmd(input hbp_cmd_t c);
		cmd       <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		sb.note_cmd(c);
		burst_left--;
		if (flood_left > 0) begin
			flood_left--;
		end else if (burst_left <= 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(7, 1)) @(posedge clk);
			burst_left = ($urandom_range(5) == 0) ? 40 : $urandom_range(12, 1);
		end
	endtask

	task automatic drain_bytes();
		cmd_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	// Receiver: checks every byte taken and stalls on patterns of its own.
	initial begin
		stall_mode_e mode;
		int          mode_left;
		int          hold_seen;
		int          hold_left;
		int          cyc;
		logic        nxt;
		mode      = STALL_NONE;
		mode_left = 0;
		hold_seen = 0;
		hold_left = 0;
		cyc       = 0;
		pkt_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pkt_valid && !pkt_stall)
				sb.check_pkt(pkt);
			cyc++;
			if (hold_seen != hold_ask) begin
				hold_seen = hold_ask;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				nxt = 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode      = stall_mode_e'($urandom_range(3));
					mode_left = $urandom_range(80, 16);
				end
				mode_left--;
				case (mode)
					STALL_NONE:     nxt = 1'b0;
					STALL_HALF:     nxt = 1'($urandom_range(1));
					STALL_PERIODIC: nxt = (cyc % 4) == 0;
					default:        nxt = $urandom_range(3) != 0;
				endcase
			end
			pkt_stall <= nxt;
		end
	end

	initial begin
		#2000000;
		$display("huffman_bit_packer_core verification failed");
		$finish;
	end

	initial begin
		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		cmd       <= '0;
		hold_ask   = 0;
		flood_left = 0;
		burst_left = 6;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: table extremes, saturation, stray bits, empty flush, zero length.
		offer_cmd(load_cmd(8'd0, 32'hFFFF_FFFF, 6'd32));
		offer_cmd(load_cmd(8'd255, 32'h0000_0000, 6'd1));
		offer_cmd(load_cmd(8'd1, 32'h0000_00A5, 6'd8));
		offer_cmd(load_cmd(8'd2, 32'h0000_0005, 6'd3));
		offer_cmd(load_cmd(8'd3, 32'h1234_5678, 6'd0));
		offer_cmd(load_cmd(8'd4, 32'h1234_5678, 6'd63));
		offer_cmd(load_cmd(8'd5, 32'hDEAD_BEEF, 6'd33));
		offer_cmd(load_cmd(8'd6, 32'hFFFF_FFFE, 6'd2));
		offer_cmd(op_cmd(KIND_UNUSED, 8'd0));
		offer_cmd(op_cmd(KIND_FLUSH, 8'd255));
		offer_cmd(op_cmd(KIND_ENCODE, 8'd0));
		offer_cmd(op_cmd(KIND_ENCODE, 8'd2));
		offer_cmd(op_cmd(KIND_ENCODE, 8'd0));
		offer_cmd(op_cmd(KIND_FLUSH, 8'd0));
		offer_cmd(op_cmd(KIND_ENCODE, 8'd3));
		offer_cmd(op_cmd(KIND_ENCODE, 8'd255));
		offer_cmd(op_cmd(KIND_FLUSH, 8'd0));
		offer_cmd(op_cmd(KIND_ENCODE, 8'd4));
		offer_cmd(op_cmd(KIND_ENCODE, 8'd6));
		offer_cmd(op_cmd(KIND_ENCODE, 8'd5));
		offer_cmd(op_cmd(KIND_ENCODE, 8'd1));
		offer_cmd(op_cmd(KIND_ENCODE, 8'd6));
		offer_cmd(op_cmd(KIND_FLUSH, 8'd0));
		offer_cmd(op_cmd(KIND_UNUSED, 8'd255));
		offer_cmd(op_cmd(KIND_FLUSH, 8'd0));
		drain_bytes();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// Long receiver hold-off while items keep coming, so the input backs up.
			if (i == 140) begin
				hold_ask++;
				flood_left = 60;
			end
			if (i == 280)
				drain_bytes();
			offer_cmd(random_cmd());
		end
		offer_cmd(op_cmd(KIND_FLUSH, SYM_W'($urandom)));

		drain_bytes();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("huffman_bit_packer_core verification clean");
		end else begin
			$display("huffman_bit_packer_core verification failed");
		end
		$finish;
	end

endmodule
